[design/mmx_pkg.sv]
// shared types and constants for the min/max extract integer store
package mmx_pkg;

    localparam logic [2:0] CMD_ADD       = 3'd0;
    localparam logic [2:0] CMD_TAKE_OLD  = 3'd1;
    localparam logic [2:0] CMD_TAKE_NEW  = 3'd2;
    localparam logic [2:0] CMD_TAKE_MAX  = 3'd3;
    localparam logic [2:0] CMD_TAKE_MIN  = 3'd4;
    localparam logic [2:0] CMD_AVERAGE   = 3'd5;
    localparam logic [2:0] CMD_SET_CAP   = 3'd6;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EMPTY      = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_REJECT     = 2'd3;

    localparam logic [1:0] REG_MIN_CAP   = 2'd0;
    localparam logic [6:0] MIN_CAP_RESET = 7'd8;

    typedef struct packed {
        logic capture;
        logic simple;
        logic sel_pos;
        logic scan_start;
        logic scan_step;
        logic div_start;
        logic div_step;
        logic div_end;
        logic fetch;
        logic take;
        logic shift_step;
        logic shrink;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic multi;
        logic pos_cmd;
        logic avg_cmd;
        logic scan_done;
        logic div_done;
        logic shift_done;
    } t_dp_stat;

endpackage

[design/mmx_datapath.sv]
// datapath: value memory, scan/accumulate, serial divider, capacity logic, result registers
module mmx_datapath
    import mmx_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [2:0]          i_command,
    input  logic signed [31:0]  i_operand,
    input  logic [6:0]          i_min_cap,
    output logic signed [31:0]  o_result_value,
    output logic [6:0]          o_capacity_now,
    output logic [6:0]          o_entry_count,
    output logic [1:0]          o_status
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int KW  = (CW > 7) ? CW : 7;
    localparam int SW  = 32 + CW;
    localparam int DCW = $clog2(SW);
    localparam logic [KW-1:0] DEPTH_K = KW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [31:0]          r_mem [DEPTH];
    logic [31:0]          r_rdata;
    logic [2:0]           r_cmd;
    logic [31:0]          r_operand;
    logic [CW-1:0]        r_count, n_count;
    logic [KW-1:0]        r_cap, n_cap;
    logic [CW-1:0]        r_idx;
    logic                 r_rd_vld;
    logic [AW-1:0]        r_rd_idx;
    logic [AW-1:0]        r_best_idx;
    logic signed [31:0]   r_best_val;
    logic signed [SW-1:0] r_acc;
    logic [SW-1:0]        r_quo;
    logic [CW-1:0]        r_rem;
    logic [DCW-1:0]       r_div_cnt;
    logic                 r_neg;
    logic [31:0]          r_result;
    logic [1:0]           r_status, n_status;
    logic [31:0]          r_out_result;
    logic [6:0]           r_out_cap;
    logic [6:0]           r_out_count;
    logic [1:0]           r_out_status;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [AW-1:0]        w_raddr;
    logic [31:0]          w_wdata;
    logic [CW-1:0]        w_last;
    logic [CW:0]          w_idx_nx;
    logic                 w_more;
    logic [CW:0]          w_trial;
    logic                 w_ge;
    logic [SW-1:0]        w_mag;
    logic [SW-1:0]        w_quo_neg;
    logic                 w_better;
    logic                 w_is_max;
    logic [KW:0]          w_grow;
    logic [KW:0]          w_grow_c;
    logic                 w_bad_cap;
    logic [CW-1:0]        w_cnew;
    logic [KW-1:0]        w_empty;
    logic [KW+1:0]        w_four_empty;
    logic [KW+1:0]        w_three_cap;
    logic [KW-1:0]        w_s1, w_s2, w_s3;

    assign w_last   = r_count - CW'(1);
    assign w_idx_nx = (CW+1)'(r_idx) + (CW+1)'(1);
    assign w_more   = w_idx_nx < (CW+1)'(r_count);
    assign w_is_max = (r_cmd == CMD_TAKE_MAX);

    assign o_stat.multi      = (r_cmd >= CMD_TAKE_OLD) && (r_cmd <= CMD_AVERAGE)
                               && (r_count != '0);
    assign o_stat.pos_cmd    = (r_cmd == CMD_TAKE_OLD) || (r_cmd == CMD_TAKE_NEW);
    assign o_stat.avg_cmd    = (r_cmd == CMD_AVERAGE);
    assign o_stat.scan_done  = r_rd_vld && ((CW'(r_rd_idx) + CW'(1)) == r_count);
    assign o_stat.div_done   = (r_div_cnt == DCW'(SW - 1));
    assign o_stat.shift_done = !w_more && !r_rd_vld;

    // memory ports
    always_comb begin
        w_raddr = r_idx[AW-1:0];
        if (i_cmd.fetch) begin
            w_raddr = r_best_idx;
        end else if (i_cmd.shift_step) begin
            w_raddr = w_idx_nx[AW-1:0];
        end
        w_we    = 1'b0;
        w_waddr = r_rd_idx;
        w_wdata = r_rdata;
        if (i_cmd.simple && r_cmd == CMD_ADD && r_count < DEPTH_C) begin
            w_we    = 1'b1;
            w_waddr = r_count[AW-1:0];
            w_wdata = r_operand;
        end else if (i_cmd.shift_step && r_rd_vld) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // running extreme, ties keep the older entry
    always_comb begin
        if (r_rd_idx == '0) begin
            w_better = 1'b1;
        end else if (w_is_max) begin
            w_better = $signed(r_rdata) > r_best_val;
        end else begin
            w_better = $signed(r_rdata) < r_best_val;
        end
    end

    // divider, one quotient bit per cycle
    assign w_trial   = {r_rem, r_quo[SW-1]};
    assign w_ge      = w_trial >= (CW+1)'(r_count);
    assign w_mag     = r_acc[SW-1] ? (~r_acc + SW'(1)) : r_acc;
    assign w_quo_neg = ~r_quo + SW'(1);

    // growth on add
    always_comb begin
        w_grow = (r_cap == '0) ? (KW+1)'(1) : ((KW+1)'(r_cap) << 1);
        if (w_grow > (KW+1)'(DEPTH)) begin
            w_grow = (KW+1)'(DEPTH);
        end
        w_grow_c = w_grow;
        if (w_grow < (KW+1)'(r_count) + (KW+1)'(1)) begin
            w_grow_c = (KW+1)'(r_count) + (KW+1)'(1);
        end
    end

    assign w_bad_cap = r_operand[31] || (r_operand > 32'(DEPTH))
                       || (r_operand < 32'(r_count));

    // shrink after take or average
    assign w_cnew       = o_stat.avg_cmd ? r_count : w_last;
    assign w_empty      = r_cap - KW'(w_cnew);
    assign w_four_empty = (KW+2)'(w_empty) << 2;
    assign w_three_cap  = ((KW+2)'(r_cap) << 1) + (KW+2)'(r_cap);
    always_comb begin
        w_s1 = r_cap >> 1;
        if (KW'(i_min_cap) > w_s1) begin
            w_s1 = KW'(i_min_cap);
        end
        w_s2 = w_s1;
        if (KW'(w_cnew) > w_s2) begin
            w_s2 = KW'(w_cnew);
        end
        w_s3 = (w_s2 > DEPTH_K) ? DEPTH_K : w_s2;
    end

    always_comb begin
        n_count  = r_count;
        n_cap    = r_cap;
        n_status = r_status;
        if (i_cmd.capture) begin
            n_status = ST_OK;
        end else if (i_cmd.simple) begin
            case (r_cmd)
                CMD_ADD: begin
                    if (r_count >= DEPTH_C) begin
                        n_status = ST_FULL;
                    end else begin
                        if (KW'(r_count) >= r_cap) begin
                            n_cap = w_grow_c[KW-1:0];
                        end
                        n_count = r_count + CW'(1);
                    end
                end
                CMD_TAKE_OLD, CMD_TAKE_NEW, CMD_TAKE_MAX, CMD_TAKE_MIN, CMD_AVERAGE: begin
                    n_status = ST_EMPTY;
                end
                CMD_SET_CAP: begin
                    if (w_bad_cap) begin
                        n_status = ST_REJECT;
                    end else begin
                        n_cap = KW'(r_operand[CW-1:0]);
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.shrink) begin
            n_count = w_cnew;
            if (w_four_empty >= w_three_cap) begin
                n_cap = w_s3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= KW'(MIN_CAP_RESET);
        end else begin
            r_count <= n_count;
            r_cap   <= n_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (i_cmd.capture) begin
            r_cmd     <= i_command;
            r_operand <= i_operand;
            r_result  <= '0;
        end
        if (i_cmd.sel_pos) begin
            r_best_idx <= (r_cmd == CMD_TAKE_OLD) ? '0 : w_last[AW-1:0];
        end
        if (i_cmd.scan_start) begin
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_acc      <= '0;
            r_best_idx <= '0;
        end
        if (i_cmd.scan_step) begin
            r_rd_vld <= r_idx < r_count;
            r_rd_idx <= r_idx[AW-1:0];
            if (r_idx < r_count) begin
                r_idx <= r_idx + CW'(1);
            end
            if (r_rd_vld) begin
                r_acc <= r_acc + SW'($signed(r_rdata));
                if (w_better) begin
                    r_best_val <= $signed(r_rdata);
                    r_best_idx <= r_rd_idx;
                end
            end
        end
        if (i_cmd.div_start) begin
            r_quo     <= w_mag;
            r_neg     <= r_acc[SW-1];
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= w_ge ? CW'(w_trial - (CW+1)'(r_count)) : w_trial[CW-1:0];
            r_quo     <= {r_quo[SW-2:0], w_ge};
            r_div_cnt <= r_div_cnt + DCW'(1);
        end
        if (i_cmd.div_end) begin
            r_result <= r_neg ? w_quo_neg[31:0] : r_quo[31:0];
        end
        if (i_cmd.take) begin
            r_result <= r_rdata;
            r_idx    <= CW'(r_best_idx);
            r_rd_vld <= 1'b0;
        end
        if (i_cmd.shift_step) begin
            r_rd_vld <= w_more;
            r_rd_idx <= r_idx[AW-1:0];
            if (w_more) begin
                r_idx <= w_idx_nx[CW-1:0];
            end
        end
        if (i_cmd.finish) begin
            r_out_result <= r_result;
            r_out_cap    <= 7'(r_cap);
            r_out_count  <= 7'(r_count);
            r_out_status <= r_status;
        end
    end

    assign o_result_value = r_out_result;
    assign o_capacity_now = r_out_cap;
    assign o_entry_count  = r_out_count;
    assign o_status       = r_out_status;

endmodule

[design/mmx_ctrl.sv]
// controller: sequences each command through the datapath and owns the handshakes
module mmx_ctrl
    import mmx_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SCAN, S_DIVINIT, S_DIV, S_DIVEND,
        S_FETCH, S_TAKE, S_SHIFT, S_SHRINK, S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_stat.multi) begin
                    o_cmd.simple = 1'b1;
                    n_state      = S_FINISH;
                end else if (i_stat.pos_cmd) begin
                    o_cmd.sel_pos = 1'b1;
                    n_state       = S_FETCH;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = i_stat.avg_cmd ? S_DIVINIT : S_FETCH;
                end
            end
            S_DIVINIT: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_DIVEND;
                end
            end
            S_DIVEND: begin
                o_cmd.div_end = 1'b1;
                n_state       = S_SHRINK;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_TAKE;
            end
            S_TAKE: begin
                o_cmd.take = 1'b1;
                n_state    = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.shift_done) begin
                    n_state = S_SHRINK;
                end
            end
            S_SHRINK: begin
                o_cmd.shrink = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[design/min_max_extract_integer_store.sv]
// add, set capacity and errors finish straight from decode without a scan
// take oldest/newest: fetch and take, then a one-entry-per-cycle close-up of later entries
// take largest/smallest: scan plus close-up through one memory port
// average: scan plus a one-bit-per-cycle divider
// one transaction at a time; a new one is taken while the previous result waits
// synchronous active-low reset: store empty, capacity and min_capacity = 8, memory not cleared
module min_max_extract_integer_store
    import mmx_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_operand,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_result_value,
    output logic [6:0]         o_capacity_now,
    output logic [6:0]         o_entry_count,
    output logic [1:0]         o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_dp_cmd    w_cmd;
    t_dp_stat   w_stat;
    logic [6:0] r_min_cap;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_MIN_CAP) ? 32'(r_min_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_cap <= MIN_CAP_RESET;
        end else if (psel && penable && pwrite && paddr == REG_MIN_CAP) begin
            r_min_cap <= pwdata[6:0];
        end
    end

    mmx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    mmx_datapath #(.DEPTH(DEPTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_command      (i_command),
        .i_operand      (i_operand),
        .i_min_cap      (r_min_cap),
        .o_result_value (o_result_value),
        .o_capacity_now (o_capacity_now),
        .o_entry_count  (o_entry_count),
        .o_status       (o_status)
    );

`ifndef SYNTH
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("transaction accepted while another is in flight");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> (o_result_value == '0))
        else $error("empty status with nonzero result");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL || o_status == ST_REJECT))
        |-> (o_result_value == '0))
        else $error("error status with nonzero result");
`endif

endmodule
